### hw/rtl/box_sphere_point_min_distance_core_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef BOX_SPHERE_POINT_MIN_DISTANCE_CORE_MACROS_SVH
`define BOX_SPHERE_POINT_MIN_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BSPMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bspmd: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define BSPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bspmd: next-cycle check failed");

`endif

### hw/rtl/bspmd_pkg.sv
package bspmd_pkg;

    // Spatial axes handled per beat.
    localparam int AXES = 3;

    // Pipeline advance and beat-valid handed to the square-root pipe.
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

### hw/rtl/bspmd_if.sv
interface bspmd_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                       valid;
    logic                       ready;
    logic [2*COORD_WIDTH-1:0]   a_x_span;
    logic [2*COORD_WIDTH-1:0]   a_y_span;
    logic [2*COORD_WIDTH-1:0]   a_z_span;
    logic [2*COORD_WIDTH-1:0]   b_x_span;
    logic [2*COORD_WIDTH-1:0]   b_y_span;
    logic [2*COORD_WIDTH-1:0]   b_z_span;
    logic [COORD_WIDTH-1:0]     radius_a;
    logic [COORD_WIDTH-1:0]     radius_b;

    modport source (
        output valid, a_x_span, a_y_span, a_z_span,
        output b_x_span, b_y_span, b_z_span, radius_a, radius_b,
        input  ready
    );
    modport sink (
        input  valid, a_x_span, a_y_span, a_z_span,
        input  b_x_span, b_y_span, b_z_span, radius_a, radius_b,
        output ready
    );
endinterface

interface bspmd_out_if #(
    parameter int COORD_WIDTH = 24
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH:0]   gap_distance;

    modport source (
        output valid, gap_distance,
        input  ready
    );
    modport sink (
        input  valid, gap_distance,
        output ready
    );
endinterface

### hw/rtl/bspmd_isqrt.sv
`include "box_sphere_point_min_distance_core_macros.svh"

// Floor square root, one result bit per stage, ROOT_W stages.
module bspmd_isqrt #(
    parameter int SUM_W  = 52,
    parameter int ROOT_W = 26,
    parameter int SIDE_W = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bspmd_pkg::t_pipe_ctl    i_ctl,
    input  logic [SUM_W-1:0]        i_rad,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic [ROOT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]       o_side
);

    logic [SUM_W-1:0]  r_rem  [ROOT_W];
    logic [SUM_W-1:0]  r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        // trial bit 4^i, i running from ROOT_W-1 down to 0
        localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (2*(ROOT_W-1-s));

        logic [SUM_W-1:0]  rem_in;
        logic [SUM_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [SUM_W:0]    trial;
        logic              fits;
        logic [SUM_W-1:0]  n_rem;
        logic [SUM_W-1:0]  n_root;

        if (s == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_ctl.vld;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        always_comb begin
            trial = {1'b0, root_in} + BIT;
            fits  = ({1'b0, rem_in} >= trial);
            if (fits) begin
                n_rem  = rem_in - trial[SUM_W-1:0];
                n_root = (root_in >> 1) + BIT[SUM_W-1:0];
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_side[s] <= side_in;
            end
        end
    end

    logic [SUM_W-1:0] last_rem;
    logic [SUM_W-1:0] last_root;

    assign last_rem  = r_rem[ROOT_W-1];
    assign last_root = r_root[ROOT_W-1];

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = last_root[ROOT_W-1:0];
    assign o_side = r_side[ROOT_W-1];

    // leftover n - r^2 never exceeds 2r for a floor root
    `BSPMD_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, o_vld, last_rem <= {last_root[SUM_W-2:0], 1'b0})
    // root fits in ROOT_W bits
    `BSPMD_ASSERT_NOW(a_root_fits, i_clk, i_rst_n, o_vld, last_root[SUM_W-1:ROOT_W] == '0)

endmodule

### hw/rtl/box_sphere_point_min_distance_core.sv
// Minimum distance between two shapes (box, point or sphere) on 3 axes.
// Input channel i_in: one beat per query, six spans (low bound in the upper
// half, high bound in the lower half, signed) plus two unsigned radii.
// Output channel o_out: one beat per query, gap_distance, unsigned, zero when
// the shapes touch or overlap, all ones when the distance exceeds the field.
// Binary point position is irrelevant to the logic; default is 8 fraction bits.
// Pipeline: four front stages (per-axis gaps, gap sum, square, sum of squares),
// COORD_WIDTH + 2 square-root stages at one root bit each, one radius-subtract
// stage and the output register.
// Throughput: one beat per cycle while the skid slot is empty, set by the fully
// pipelined datapath.
// Back-pressure: an output register plus one skid register sit behind the
// pipe. The pipe advances while the skid is empty, so i_in.ready depends
// only on registered state and a new beat is taken while a result waits.
// Reset (synchronous, active low) clears all valid bits; in-flight beats drop.
module box_sphere_point_min_distance_core #(
    parameter int COORD_WIDTH = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bspmd_in_if.sink        i_in,
    bspmd_out_if.source     o_out
);

    `include "box_sphere_point_min_distance_core_macros.svh"

    localparam int CW     = COORD_WIDTH;
    localparam int GAP_W  = CW + 1;         // two positive parts added
    localparam int SQ_W   = 2 * GAP_W;
    localparam int SUM_W  = SQ_W + 2;       // three squares
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int OUT_W  = CW + 1;

    // pipe advances whenever the skid slot is free
    logic r_skid_vld;
    logic en;
    assign en = !r_skid_vld;
    assign i_in.ready = en;

    // ---- spans per axis
    logic [2*CW-1:0] a_span [bspmd_pkg::AXES];
    logic [2*CW-1:0] b_span [bspmd_pkg::AXES];
    assign a_span[0] = i_in.a_x_span;
    assign a_span[1] = i_in.a_y_span;
    assign a_span[2] = i_in.a_z_span;
    assign b_span[0] = i_in.b_x_span;
    assign b_span[1] = i_in.b_y_span;
    assign b_span[2] = i_in.b_z_span;

    // ---- stage 1: positive parts of a_lo-b_hi and b_lo-a_hi, radius sum
    logic [CW-1:0] r1_pos_ab [bspmd_pkg::AXES];
    logic [CW-1:0] r1_pos_ba [bspmd_pkg::AXES];
    logic [CW-1:0] n1_pos_ab [bspmd_pkg::AXES];
    logic [CW-1:0] n1_pos_ba [bspmd_pkg::AXES];
    logic [CW:0]   d_ab      [bspmd_pkg::AXES];
    logic [CW:0]   d_ba      [bspmd_pkg::AXES];
    logic [CW:0]   r1_rsum;
    logic          r1_vld;

    always_comb begin
        for (int k = 0; k < bspmd_pkg::AXES; k++) begin
            // sign-extended differences, CW+1 bits
            d_ab[k] = {a_span[k][2*CW-1], a_span[k][2*CW-1:CW]}
                    - {b_span[k][CW-1], b_span[k][CW-1:0]};
            d_ba[k] = {b_span[k][2*CW-1], b_span[k][2*CW-1:CW]}
                    - {a_span[k][CW-1], a_span[k][CW-1:0]};
            n1_pos_ab[k] = d_ab[k][CW] ? '0 : d_ab[k][CW-1:0];
            n1_pos_ba[k] = d_ba[k][CW] ? '0 : d_ba[k][CW-1:0];
        end
    end

    // ---- stage 2: per-axis gap
    logic [GAP_W-1:0] r2_gap [bspmd_pkg::AXES];
    logic [GAP_W-1:0] n2_gap [bspmd_pkg::AXES];
    logic [CW:0]      r2_rsum;
    logic             r2_vld;

    always_comb begin
        for (int k = 0; k < bspmd_pkg::AXES; k++) begin
            n2_gap[k] = {1'b0, r1_pos_ab[k]} + {1'b0, r1_pos_ba[k]};
        end
    end

    // ---- stage 3: squares
    logic [SQ_W-1:0] r3_sq [bspmd_pkg::AXES];
    logic [SQ_W-1:0] n3_sq [bspmd_pkg::AXES];
    logic [CW:0]     r3_rsum;
    logic            r3_vld;

    always_comb begin
        for (int k = 0; k < bspmd_pkg::AXES; k++) begin
            n3_sq[k] = SQ_W'(r2_gap[k]) * SQ_W'(r2_gap[k]);
        end
    end

    // ---- stage 4: sum of squares
    logic [SUM_W-1:0] r4_sum;
    logic [SUM_W-1:0] n4_sum;
    logic [CW:0]      r4_rsum;
    logic             r4_vld;

    assign n4_sum = SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pos_ab <= n1_pos_ab;
            r1_pos_ba <= n1_pos_ba;
            r1_rsum   <= {1'b0, i_in.radius_a} + {1'b0, i_in.radius_b};
            r2_gap    <= n2_gap;
            r2_rsum   <= r1_rsum;
            r3_sq     <= n3_sq;
            r3_rsum   <= r2_rsum;
            r4_sum    <= n4_sum;
            r4_rsum   <= r3_rsum;
        end
    end

    // ---- square-root pipe, radius sum rides along
    bspmd_pkg::t_pipe_ctl sq_ctl;
    logic                 sq_vld;
    logic [ROOT_W-1:0]    sq_root;
    logic [OUT_W-1:0]     sq_rsum;

    assign sq_ctl = '{en: en, vld: r4_vld};

    bspmd_isqrt #(
        .SUM_W  (SUM_W),
        .ROOT_W (ROOT_W),
        .SIDE_W (OUT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_rad   (r4_sum),
        .i_side  (r4_rsum),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_rsum)
    );

    // ---- stage 5: subtract radii, clamp at zero, saturate high
    logic [ROOT_W-1:0] rsum_ext;
    logic [ROOT_W-1:0] diff;
    logic [OUT_W-1:0]  n5_res;
    logic [OUT_W-1:0]  r5_res;
    logic              r5_vld;

    always_comb begin
        rsum_ext = ROOT_W'(sq_rsum);
        diff     = sq_root - rsum_ext;
        if (sq_root <= rsum_ext) begin
            n5_res = '0;
        end else if (diff[ROOT_W-1]) begin
            n5_res = '1;
        end else begin
            n5_res = diff[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_res <= n5_res;
        end
    end

    // ---- output register and skid slot
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] r_skid_data;
    logic             take;
    logic             push;

    assign take = r_out_vld && o_out.ready;
    assign push = en && r5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= push;
            end
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || take) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
            end else if (push) begin
                r_out_data <= r5_res;
            end
        end else if (push) begin
            r_skid_data <= r5_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.gap_distance = r_out_data;

    // skid only fills behind a held output beat
    `BSPMD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // a beat leaving the pipe into a stalled output lands in the skid
    `BSPMD_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, r_out_vld && !take && push, r_skid_vld)
    // skid drains into the output as soon as the held beat is taken
    `BSPMD_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld && o_out.ready, r_out_vld && !r_skid_vld)

endmodule

### dv/box_sphere_point_min_distance_core_test.sv
`timescale 1ns / 1ps

// Checks the shape distance core against an in-bench model of the distance
// maths: per-axis interval gaps, sum of squares, floor root, radius clamp and
// output saturation. Queries go in through the input channel with random gaps,
// results come back through a randomly stalled output channel and are matched
// in order against a queue of predicted distances.
module box_sphere_point_min_distance_core_test;

    localparam int      CW           = 24;
    localparam int      U            = 256;                  // 1.0 in Q.8
    localparam int      C_MAX        = 2**(CW-1) - 1;
    localparam int      C_MIN        = -(2**(CW-1));
    localparam int      R_MAX        = 2**CW - 1;
    localparam longint  OUT_MAX      = (longint'(1) << (CW+1)) - 1;
    localparam int      DRAIN_CYCLES = CW + 7 + 20;          // pipe latency plus margin

    typedef enum logic [1:0] {SHAPE_BOX, SHAPE_POINT, SHAPE_SPHERE} t_shape_kind;

    // One query: spans 0..2 are shape A (x, y, z), 3..5 shape B.
    typedef struct packed {
        logic [5:0][2*CW-1:0]   span;
        logic [CW-1:0]          radius_a;
        logic [CW-1:0]          radius_b;
    } t_query;

    typedef struct {
        int             id;
        logic [CW:0]    gap;
    } t_distance_due;

    logic clk;
    logic rst_n;

    bspmd_in_if  #(.COORD_WIDTH(CW)) in_bus ();
    bspmd_out_if #(.COORD_WIDTH(CW)) out_bus ();

    box_sphere_point_min_distance_core #(
        .COORD_WIDTH(CW)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    t_distance_due  pending_distances[$];
    int             n_queries;
    int             n_results;
    int             n_zero;
    int             n_saturated;
    int             err_count;
    bit             no_idle;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Distance model
    // ------------------------------------------------------------------
    function automatic logic [CW:0] predict_gap_distance(input t_query q);
        longint a_lo, a_hi, b_lo, b_hi;
        longint gap, sum_sq, root, trial, ra, rb, res;
        sum_sq = 0;
        for (int k = 0; k < bspmd_pkg::AXES; k++) begin
            a_lo = longint'($signed(q.span[k][2*CW-1:CW]));
            a_hi = longint'($signed(q.span[k][CW-1:0]));
            b_lo = longint'($signed(q.span[k+3][2*CW-1:CW]));
            b_hi = longint'($signed(q.span[k+3][CW-1:0]));
            // Inverted intervals are taken as they are: both terms may add.
            gap = ((a_lo - b_hi) > 0 ? (a_lo - b_hi) : 0)
                + ((b_lo - a_hi) > 0 ? (b_lo - a_hi) : 0);
            sum_sq += gap * gap;
        end
        // Sum stays below 2^52, so the root fits in 27 bits.
        root = 0;
        for (int b = 27; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        ra = longint'(q.radius_a);
        rb = longint'(q.radius_b);
        res = (root <= ra + rb) ? 0 : root - ra - rb;
        if (res > OUT_MAX)
            res = OUT_MAX;
        return res[CW:0];
    endfunction

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Sink side: ready drops for random stretches.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_cycles();
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk) begin : check_results
        t_distance_due due;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            n_results++;
            if (pending_distances.size() == 0) begin
                report_mismatch($sformatf("result %0d with no query outstanding",
                                          out_bus.gap_distance));
            end else begin
                due = pending_distances.pop_front();
                if (out_bus.gap_distance !== due.gap)
                    report_mismatch($sformatf("query %0d gap_distance %0d, want %0d",
                                              due.id, out_bus.gap_distance, due.gap));
                if (due.gap == 0)
                    n_zero++;
                else if (due.gap == OUT_MAX[CW:0])
                    n_saturated++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Sends one beat; returns at the rising edge that accepts it. Valid is
    // left high so that back-to-back beats go out without a gap.
    task automatic send_query(input t_query q);
        int unsigned gap;
        t_distance_due due;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.a_x_span <= q.span[0];
        in_bus.a_y_span <= q.span[1];
        in_bus.a_z_span <= q.span[2];
        in_bus.b_x_span <= q.span[3];
        in_bus.b_y_span <= q.span[4];
        in_bus.b_z_span <= q.span[5];
        in_bus.radius_a <= q.radius_a;
        in_bus.radius_b <= q.radius_b;
        do
            @(posedge clk);
        while (!in_bus.ready);
        due.id  = n_queries;
        due.gap = predict_gap_distance(q);
        pending_distances.push_back(due);
        n_queries++;
    endtask

    function automatic logic [2*CW-1:0] span_of(input int lo, input int hi);
        logic [CW-1:0] l, h;
        l = CW'(lo);
        h = CW'(hi);
        return {l, h};
    endfunction

    function automatic t_query query_of(input logic [2*CW-1:0] ax, ay, az,
                                        input logic [2*CW-1:0] bx, by, bz,
                                        input int ra, input int rb);
        t_query q;
        q.span[0]  = ax;
        q.span[1]  = ay;
        q.span[2]  = az;
        q.span[3]  = bx;
        q.span[4]  = by;
        q.span[5]  = bz;
        q.radius_a = CW'(ra);
        q.radius_b = CW'(rb);
        return q;
    endfunction

    // Signed coordinate with a magnitude of up to 'scale' bits.
    function automatic logic [CW-1:0] rand_coord(input int unsigned scale);
        logic [CW-1:0] mag;
        mag = CW'($urandom() & ((32'd1 << scale) - 1));
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    // Well-formed shape: box with lo <= hi (unless the extent wraps at the
    // widest scale), a point, or a point with a radius.
    function automatic void build_shape(input t_shape_kind kind, input int unsigned scale,
                                        output logic [2:0][2*CW-1:0] spans,
                                        output logic [CW-1:0] radius);
        logic [CW-1:0] lo, hi;
        for (int k = 0; k < 3; k++) begin
            lo = rand_coord(scale);
            hi = (kind == SHAPE_BOX) ? lo + CW'($urandom_range(0, 1 << (scale - 1))) : lo;
            spans[k] = {lo, hi};
        end
        radius = (kind == SHAPE_SPHERE) ? CW'($urandom() & ((32'd1 << scale) - 1)) : '0;
    endfunction

    function automatic t_query random_query();
        t_query q;
        logic [2:0][2*CW-1:0] spans;
        logic [CW-1:0] radius;
        logic [63:0] r64;
        logic [31:0] r32;
        int unsigned scale;
        if ($urandom_range(0, 99) < 15) begin
            // Noise: every bit of every field at random.
            for (int k = 0; k < 6; k++) begin
                r64 = {$urandom(), $urandom()};
                q.span[k] = r64[2*CW-1:0];
            end
            r32 = $urandom();
            q.radius_a = r32[CW-1:0];
            r32 = $urandom();
            q.radius_b = r32[CW-1:0];
            return q;
        end
        // Small scales keep shapes close so overlaps and clamps are common.
        case ($urandom_range(0, 3))
            0:       scale = 6;
            1:       scale = 12;
            2:       scale = 18;
            default: scale = CW - 1;
        endcase
        build_shape(t_shape_kind'($urandom_range(0, 2)), scale, spans, radius);
        for (int k = 0; k < 3; k++)
            q.span[k] = spans[k];
        q.radius_a = radius;
        build_shape(t_shape_kind'($urandom_range(0, 2)), scale, spans, radius);
        for (int k = 0; k < 3; k++)
            q.span[k+3] = spans[k];
        q.radius_b = radius;
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every pairing of box, point and sphere; point-point and box-box also overlap.
    task automatic test_shape_pairs();
        logic [2*CW-1:0] unit_box, wide_box, origin;
        unit_box = span_of(0, U);
        wide_box = span_of(-U, U);
        origin   = span_of(0, 0);
        // point-point, coincident and at a 3-4-5 distance
        send_query(query_of(origin, origin, origin, origin, origin, origin, 0, 0));
        send_query(query_of(origin, origin, origin,
                            span_of(3*U, 3*U), span_of(4*U, 4*U), origin, 0, 0));
        // box-box apart on x, then overlapping
        send_query(query_of(unit_box, unit_box, unit_box,
                            span_of(3*U, 4*U), unit_box, unit_box, 0, 0));
        send_query(query_of(unit_box, unit_box, unit_box,
                            span_of(U/2, 2*U), unit_box, unit_box, 0, 0));
        // box-point and box-sphere
        send_query(query_of(wide_box, wide_box, wide_box,
                            span_of(2*U, 2*U), span_of(-3*U, -3*U), span_of(U, U), 0, 0));
        send_query(query_of(wide_box, wide_box, wide_box,
                            span_of(2*U, 2*U), span_of(-3*U, -3*U), span_of(U, U), 0, 100));
        // point-sphere and sphere-sphere
        send_query(query_of(span_of(-U, -U), span_of(-U, -U), span_of(-U, -U),
                            span_of(5*U, 5*U), span_of(7*U, 7*U), span_of(-U, -U), 0, 3*U));
        send_query(query_of(origin, origin, origin,
                            origin, origin, span_of(12*U, 12*U), U, 2*U));
    endtask

    // Field extremes: all zeros, all ones, opposite corners, largest radii.
    task automatic test_field_extremes();
        logic [2*CW-1:0] ones, top, bottom, full;
        ones   = '1;
        top    = span_of(C_MAX, C_MAX);
        bottom = span_of(C_MIN, C_MIN);
        full   = span_of(C_MIN, C_MAX);
        send_query('0);
        send_query(query_of(ones, ones, ones, ones, ones, ones, R_MAX, R_MAX));
        send_query(query_of(top, top, top, bottom, bottom, bottom, 0, 0));
        send_query(query_of(top, top, top, bottom, bottom, bottom, R_MAX, 0));
        send_query(query_of(top, top, top, bottom, bottom, bottom, R_MAX, R_MAX));
        send_query(query_of(full, full, full, top, bottom, top, 0, 0));
    endtask

    // Low bound above high bound: both gap terms contribute.
    task automatic test_inverted_intervals();
        logic [2*CW-1:0] flipped, origin;
        flipped = span_of(C_MAX, C_MIN);
        origin  = span_of(0, 0);
        send_query(query_of(span_of(U, -U), origin, origin, origin, origin, origin, 0, 0));
        send_query(query_of(span_of(0, U), span_of(2*U, -2*U), span_of(0, U),
                            span_of(5*U, 6*U), span_of(0, U), span_of(0, U), 0, 0));
        // Widest possible gaps: the root exceeds the output field and saturates.
        send_query(query_of(flipped, flipped, flipped, flipped, flipped, flipped, 0, 0));
    endtask

    // Radii at, just below and far above the centre distance.
    task automatic test_radius_clamp();
        logic [2*CW-1:0] origin;
        origin = span_of(0, 0);
        send_query(query_of(origin, origin, origin,
                            span_of(3*U, 3*U), span_of(4*U, 4*U), origin, 640, 640));
        send_query(query_of(origin, origin, origin,
                            span_of(3*U, 3*U), span_of(4*U, 4*U), origin, 640, 639));
        send_query(query_of(origin, origin, origin,
                            span_of(3*U, 3*U), span_of(4*U, 4*U), origin, R_MAX, 0));
    endtask

    // Full-rate stretch: no gaps on either side.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) send_query(random_query());
        no_idle = 1'b0;
    endtask

    task automatic test_random_queries(input int count);
        repeat (count) send_query(random_query());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        n_queries       = 0;
        n_results       = 0;
        n_zero          = 0;
        n_saturated     = 0;
        err_count       = 0;
        no_idle         = 1'b0;
        rst_n           = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.a_x_span = '0;
        in_bus.a_y_span = '0;
        in_bus.a_z_span = '0;
        in_bus.b_x_span = '0;
        in_bus.b_y_span = '0;
        in_bus.b_z_span = '0;
        in_bus.radius_a = '0;
        in_bus.radius_b = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_shape_pairs();
        test_field_extremes();
        test_inverted_intervals();
        test_radius_clamp();
        test_back_to_back(60);
        test_random_queries(420);

        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        // Any stray beat after the last expected one is still caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d shape queries (directed pairs, extremes, inverted spans, %s)",
                 n_queries, "radius clamp, random");
        $display("Checked %0d distances: %0d zero, %0d saturated, %0d mismatches",
                 n_results, n_zero, n_saturated, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
